// ===== sv/omv_pkg.sv =====
// ----------------------------------------------------------------------------
// omv_pkg
// Types and constants for the OSC message validator.
// ----------------------------------------------------------------------------
package omv_pkg;

  localparam int unsigned MaxArgsDefault        = 8;
  localparam int unsigned MaxPacketBytesDefault = 1024;
  localparam int unsigned ResFifoDepth          = 4;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharInt   = 8'h69;
  localparam logic [7:0] CharStr   = 8'h73;
  localparam logic [7:0] CharFloat = 8'h66;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam logic [9:0] AddrLenMax = 10'd1023;

  typedef enum logic [2:0] {
    PH_ADDR      = 3'd0,
    PH_ADDR_PAD  = 3'd1,
    PH_TAG_FIRST = 3'd2,
    PH_TAGS      = 3'd3,
    PH_TAG_PAD   = 3'd4,
    PH_ARGS      = 3'd5,
    PH_BODY      = 3'd6,
    PH_STR       = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ADDR    = 3'd1,
    ST_TAG_UNTERM  = 3'd2,
    ST_NO_COMMA    = 3'd3,
    ST_TOO_MANY    = 3'd4,
    ST_UNKNOWN_TAG = 3'd5,
    ST_TRUNCATED   = 3'd6,
    ST_TRAILING    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    AT_INT32   = 2'd0,
    AT_STRING  = 2'd1,
    AT_FLOAT32 = 2'd2,
    AT_NONE    = 2'd3
  } arg_type_e;

  typedef enum logic {
    KIND_DESC   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] idx;
    logic [1:0] atype;
    logic [9:0] offset;
    logic [2:0] status;
    logic [9:0] addr_len;
    logic [3:0] count;
    logic       eor;
  } res_t;

endpackage

// ===== sv/osc_message_validator_unit.sv =====
// A result is written into the result queue when its request is accepted and is presented from the queue head.
// One request per cycle while the input is not stalled; the final byte of a packet may yield two results
// (descriptor then status), drained one per cycle from a four-entry result queue while the output is not stalled.
// The input stalls while fewer than two queue entries are free.
// Reset (rst_ni low, asynchronous) returns the parser to the address phase and
// empties the queue; the tag store is not cleared and is written before use.
// ----------------------------------------------------------------------------
// osc_message_validator_unit
// Byte-serial OSC message checker emitting argument descriptors and status.
// ----------------------------------------------------------------------------
module osc_message_validator_unit import omv_pkg::*; #(
  parameter int unsigned MAX_ARGS         = MaxArgsDefault,
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       item_kind_o,
  output logic [2:0] arg_index_o,
  output logic [1:0] arg_type_o,
  output logic [9:0] arg_offset_o,
  output logic [2:0] status_o,
  output logic [9:0] address_length_o,
  output logic [3:0] tag_count_o,
  output logic       end_of_run_o
);

  localparam int unsigned CntW  = $clog2(MAX_ARGS + 1);
  localparam int unsigned IdxW  = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int unsigned PosW  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned FPtrW = $clog2(ResFifoDepth);
  localparam int unsigned FCntW = $clog2(ResFifoDepth + 1);

  localparam logic [CntW-1:0]  ArgsLimit = CntW'(MAX_ARGS);
  localparam logic [PosW-1:0]  PosLimit  = PosW'(MAX_PACKET_BYTES);
  localparam logic [FCntW-1:0] FifoFull2 = FCntW'(ResFifoDepth - 2);

  // parser state
  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [9:0]      alen_q, alen_d;
  logic [CntW-1:0] ttot_q, ttot_d;
  logic [CntW-1:0] cur_q, cur_d;
  logic [1:0]      left_q, left_d;
  status_e         err_q, err_d;
  logic [1:0]      tag_store_q [MAX_ARGS];
  logic            tag_we;
  logic [1:0]      tag_wdata;

  // result queue
  res_t             fifo_q [ResFifoDepth];
  logic [FPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCntW-1:0] fcnt_q;

  logic       accept, pop;
  logic       aligned, is_nul;
  logic [1:0] cur_type;
  logic       emit_desc;
  logic [1:0] n_res;
  res_t       desc_r, stat_r, res0, res1;

  logic [PosW+9:0] pos_ext;
  logic [CntW+2:0] cur_ext;
  logic [CntW+3:0] ttot_ext;

  assign accept   = in_valid_i && !in_stall_o;
  assign pop      = out_valid_o && !out_stall_i;
  assign aligned  = (pos_q[1:0] == 2'b11);
  assign is_nul   = (data_byte_i == CharNul);
  assign cur_type = tag_store_q[cur_q[IdxW-1:0]];

  assign pos_ext  = {10'd0, pos_q};
  assign cur_ext  = {3'd0, cur_q};
  assign ttot_ext = {4'd0, ttot_d};

  // next state
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    alen_d    = alen_q;
    ttot_d    = ttot_q;
    cur_d     = cur_q;
    left_d    = left_q;
    err_d     = err_q;
    tag_we    = 1'b0;
    tag_wdata = AT_INT32;
    emit_desc = 1'b0;
    if (accept) begin
      if (err_q == ST_OK) begin
        if (pos_q >= PosLimit) begin
          err_d = ST_TRAILING;
        end else begin
          case (phase_q)
            PH_ADDR: begin
              if (is_nul) begin
                phase_d = aligned ? PH_TAG_FIRST : PH_ADDR_PAD;
              end else if (alen_q < AddrLenMax) begin
                alen_d = alen_q + 10'd1;
              end
            end
            PH_ADDR_PAD: begin
              if (aligned) phase_d = PH_TAG_FIRST;
            end
            PH_TAG_FIRST: begin
              if (data_byte_i == CharComma) phase_d = PH_TAGS;
              else err_d = ST_NO_COMMA;
            end
            PH_TAGS: begin
              if (is_nul) begin
                cur_d   = '0;
                phase_d = aligned ? PH_ARGS : PH_TAG_PAD;
              end else if (ttot_q >= ArgsLimit) begin
                err_d = ST_TOO_MANY;
              end else if (data_byte_i == CharInt) begin
                tag_we    = 1'b1;
                tag_wdata = AT_INT32;
              end else if (data_byte_i == CharStr) begin
                tag_we    = 1'b1;
                tag_wdata = AT_STRING;
              end else if (data_byte_i == CharFloat) begin
                tag_we    = 1'b1;
                tag_wdata = AT_FLOAT32;
              end else begin
                err_d = ST_UNKNOWN_TAG;
              end
              if (tag_we) ttot_d = ttot_q + CntW'(1);
            end
            PH_TAG_PAD: begin
              if (aligned) begin
                cur_d   = '0;
                phase_d = PH_ARGS;
              end
            end
            PH_ARGS: begin
              if (cur_q >= ttot_q || cur_q >= ArgsLimit) begin
                err_d = ST_TRAILING;
              end else begin
                emit_desc = 1'b1;
                if (cur_type != AT_STRING) begin
                  left_d  = 2'd3;
                  phase_d = PH_BODY;
                end else if (is_nul) begin
                  if (aligned) begin
                    cur_d   = cur_q + CntW'(1);
                    phase_d = PH_ARGS;
                  end else begin
                    left_d  = ~pos_q[1:0];
                    phase_d = PH_BODY;
                  end
                end else begin
                  phase_d = PH_STR;
                end
              end
            end
            PH_BODY: begin
              if (left_q != 2'd0) left_d = left_q - 2'd1;
              if (left_d == 2'd0) begin
                cur_d   = cur_q + CntW'(1);
                phase_d = PH_ARGS;
              end
            end
            PH_STR: begin
              if (is_nul) begin
                if (aligned) begin
                  cur_d   = cur_q + CntW'(1);
                  phase_d = PH_ARGS;
                end else begin
                  left_d  = ~pos_q[1:0];
                  phase_d = PH_BODY;
                end
              end
            end
            default: phase_d = PH_ADDR;
          endcase
        end
      end
      if (pos_q < PosLimit) pos_d = pos_q + PosW'(1);
      if (final_byte_i && err_d == ST_OK) begin
        if (phase_d == PH_ADDR || phase_d == PH_ADDR_PAD) begin
          err_d = ST_BAD_ADDR;
        end else if (phase_d == PH_TAG_FIRST || phase_d == PH_TAGS ||
                     phase_d == PH_TAG_PAD) begin
          err_d = ST_TAG_UNTERM;
        end else if (phase_d != PH_ARGS || cur_d < ttot_d) begin
          err_d = ST_TRUNCATED;
        end
      end
    end
  end

  // results of this request
  always_comb begin
    desc_r          = '0;
    desc_r.kind     = KIND_DESC;
    desc_r.idx      = cur_ext[2:0];
    desc_r.atype    = cur_type;
    desc_r.offset   = pos_ext[9:0];
    desc_r.status   = ST_OK;
    desc_r.addr_len = alen_d;
    desc_r.count    = ttot_ext[3:0];
    desc_r.eor      = 1'b0;

    stat_r          = '0;
    stat_r.kind     = KIND_STATUS;
    stat_r.status   = err_d;
    stat_r.addr_len = alen_d;
    stat_r.count    = ttot_ext[3:0];
    stat_r.eor      = 1'b1;

    res0  = emit_desc ? desc_r : stat_r;
    res1  = stat_r;
    n_res = {1'b0, emit_desc} + {1'b0, final_byte_i};
    if (!accept) n_res = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      pos_q   <= '0;
      alen_q  <= '0;
      ttot_q  <= '0;
      cur_q   <= '0;
      left_q  <= '0;
      err_q   <= ST_OK;
    end else if (accept && final_byte_i) begin
      phase_q <= PH_ADDR;
      pos_q   <= '0;
      alen_q  <= '0;
      ttot_q  <= '0;
      cur_q   <= '0;
      left_q  <= '0;
      err_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      alen_q  <= alen_d;
      ttot_q  <= ttot_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_store_q[ttot_q[IdxW-1:0]] <= tag_wdata;
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) fifo_q[wr_ptr_q + FPtrW'(1)] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FPtrW'(n_res);
      if (pop) rd_ptr_q <= rd_ptr_q + FPtrW'(1);
      fcnt_q <= fcnt_q + FCntW'(n_res) - FCntW'(pop);
    end
  end

  assign in_stall_o       = (fcnt_q > FifoFull2);
  assign out_valid_o      = (fcnt_q != '0);
  assign item_kind_o      = fifo_q[rd_ptr_q].kind;
  assign arg_index_o      = fifo_q[rd_ptr_q].idx;
  assign arg_type_o       = fifo_q[rd_ptr_q].atype;
  assign arg_offset_o     = fifo_q[rd_ptr_q].offset;
  assign status_o         = fifo_q[rd_ptr_q].status;
  assign address_length_o = fifo_q[rd_ptr_q].addr_len;
  assign tag_count_o      = fifo_q[rd_ptr_q].count;
  assign end_of_run_o     = fifo_q[rd_ptr_q].eor;

endmodule

// ===== sv/omv_checker.sv =====
// ----------------------------------------------------------------------------
// omv_checker
// Port-level checks for the OSC message validator, bound to the top level.
// ----------------------------------------------------------------------------
module omv_checker import omv_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       item_kind_o,
  input logic [2:0] arg_index_o,
  input logic [1:0] arg_type_o,
  input logic [9:0] arg_offset_o,
  input logic [2:0] status_o,
  input logic       end_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_eor_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_of_run_o == item_kind_o))
    else $error("end_of_run does not match item kind");

  a_desc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_DESC |-> status_o == ST_OK && arg_type_o != AT_NONE)
    else $error("bad descriptor fields");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_STATUS |->
      arg_index_o == 3'd0 && arg_type_o == AT_INT32 && arg_offset_o == 10'd0)
    else $error("status item carries descriptor fields");

endmodule

bind osc_message_validator_unit omv_checker u_omv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .item_kind_o  (item_kind_o),
  .arg_index_o  (arg_index_o),
  .arg_type_o   (arg_type_o),
  .arg_offset_o (arg_offset_o),
  .status_o     (status_o),
  .end_of_run_o (end_of_run_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds OSC messages byte by byte into osc_message_validator_unit and checks
// every descriptor and status against a cycle-free model of the parser. A
// directed set of short messages hits each error class, then random messages
// (well-formed, truncated, corrupted, padded with junk, noise) run under
// random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import omv_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned RandBytes  = 230;

  class osc_parse_tracker;
    phase_e      phase;
    int unsigned pos;
    logic [9:0]  alen;
    int unsigned ntags;
    arg_type_e   tags [MaxArgsDefault];
    int unsigned cur;
    int unsigned left;
    status_e     err;
    res_t        pending_items [$];
    int unsigned mismatches;
    int unsigned desc_count;
    int unsigned status_count [8];

    function new();
      mismatches = 0;
      desc_count = 0;
      foreach (status_count[i]) status_count[i] = 0;
      foreach (tags[i]) tags[i] = AT_INT32;
      clear_packet();
    endfunction

    function void clear_packet();
      phase = PH_ADDR;
      pos   = 0;
      alen  = '0;
      ntags = 0;
      cur   = 0;
      left  = 0;
      err   = ST_OK;
    endfunction

    function void push_item(kind_e k, int unsigned idx, arg_type_e at, int unsigned off,
                            status_e st);
      res_t r;
      r.kind     = k;
      r.idx      = idx[2:0];
      r.atype    = at;
      r.offset   = off[9:0];
      r.status   = st;
      r.addr_len = alen;
      r.count    = ntags[3:0];
      r.eor      = (k == KIND_STATUS);
      pending_items.push_back(r);
    endfunction

    function void end_string(bit aligned);
      if (aligned) begin
        cur++;
        phase = PH_ARGS;
      end else begin
        left  = 3 - (pos % 4);
        phase = PH_BODY;
      end
    endfunction

    // one accepted request: advance the parser, queue what it produces
    function void take_byte(logic [7:0] b, logic fin);
      bit        aligned;
      arg_type_e t;
      aligned = ((pos + 1) % 4) == 0;
      if (err == ST_OK) begin
        if (pos >= MaxPacketBytesDefault) begin
          err = ST_TRAILING;
        end else begin
          case (phase)
            PH_ADDR: begin
              if (b == CharNul) phase = aligned ? PH_TAG_FIRST : PH_ADDR_PAD;
              else if (alen < AddrLenMax) alen++;
            end
            PH_ADDR_PAD: begin
              if (aligned) phase = PH_TAG_FIRST;
            end
            PH_TAG_FIRST: begin
              if (b == CharComma) phase = PH_TAGS;
              else err = ST_NO_COMMA;
            end
            PH_TAGS: begin
              if (b == CharNul) begin
                cur   = 0;
                phase = aligned ? PH_ARGS : PH_TAG_PAD;
              end else if (ntags >= MaxArgsDefault) begin
                err = ST_TOO_MANY;
              end else begin
                case (b)
                  CharInt:   t = AT_INT32;
                  CharStr:   t = AT_STRING;
                  CharFloat: t = AT_FLOAT32;
                  default:   t = AT_NONE;
                endcase
                if (t == AT_NONE) begin
                  err = ST_UNKNOWN_TAG;
                end else begin
                  tags[ntags] = t;
                  ntags++;
                end
              end
            end
            PH_TAG_PAD: begin
              if (aligned) begin
                cur   = 0;
                phase = PH_ARGS;
              end
            end
            PH_ARGS: begin
              if (cur >= ntags || cur >= MaxArgsDefault) begin
                err = ST_TRAILING;
              end else begin
                t = tags[cur];
                push_item(KIND_DESC, cur, t, pos, ST_OK);
                desc_count++;
                if (t != AT_STRING) begin
                  left  = 3;
                  phase = PH_BODY;
                end else if (b == CharNul) begin
                  end_string(aligned);
                end else begin
                  phase = PH_STR;
                end
              end
            end
            PH_BODY: begin
              if (left > 0) left--;
              if (left == 0) begin
                cur++;
                phase = PH_ARGS;
              end
            end
            default: begin
              if (b == CharNul) end_string(aligned);
            end
          endcase
        end
      end
      if (pos < MaxPacketBytesDefault) pos++;
      if (fin) begin
        if (err == ST_OK) begin
          if (phase == PH_ADDR || phase == PH_ADDR_PAD) err = ST_BAD_ADDR;
          else if (phase == PH_TAG_FIRST || phase == PH_TAGS || phase == PH_TAG_PAD)
            err = ST_TAG_UNTERM;
          else if (phase != PH_ARGS || cur < ntags) err = ST_TRUNCATED;
        end
        push_item(KIND_STATUS, 0, AT_INT32, 0, err);
        status_count[err]++;
        clear_packet();
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task match_item(res_t got);
      res_t want;
      if (pending_items.size() == 0) begin
        report($sformatf("result with nothing pending (kind %0d status %0d)",
                         got.kind, got.status));
        return;
      end
      want = pending_items.pop_front();
      check_field("item_kind", got.kind, want.kind);
      check_field("arg_index", got.idx, want.idx);
      check_field("arg_type", got.atype, want.atype);
      check_field("arg_offset", got.offset, want.offset);
      check_field("status", got.status, want.status);
      check_field("address_length", got.addr_len, want.addr_len);
      check_field("tag_count", got.count, want.count);
      check_field("end_of_run", got.eor, want.eor);
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       item_kind_o;
  logic [2:0] arg_index_o;
  logic [1:0] arg_type_o;
  logic [9:0] arg_offset_o;
  logic [2:0] status_o;
  logic [9:0] address_length_o;
  logic [3:0] tag_count_o;
  logic       end_of_run_o;

  osc_parse_tracker tracker = new();

  logic [7:0]  pkt_q [$];
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned burst_left;
  int unsigned holds_done;
  bit          gaps_on;
  bit          hold_req;

  osc_message_validator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_kind_o      (item_kind_o),
    .arg_index_o      (arg_index_o),
    .arg_type_o       (arg_type_o),
    .arg_offset_o     (arg_offset_o),
    .status_o         (status_o),
    .address_length_o (address_length_o),
    .tag_count_o      (tag_count_o),
    .end_of_run_o     (end_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // message building; pad bytes are random since the parser skips them
  function automatic void put_chars(string s);
    for (int i = 0; i < s.len(); i++) pkt_q.push_back(s[i]);
  endfunction

  function automatic void end_str();
    pkt_q.push_back(CharNul);
    while (pkt_q.size() % 4 != 0) pkt_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_str(string s);
    put_chars(s);
    end_str();
  endfunction

  function automatic void put_word();
    repeat (4) pkt_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_rand_str(int unsigned n);
    repeat (n) pkt_q.push_back(8'($urandom_range(1, 255)));
    end_str();
  endfunction

  function automatic void build_random_packet();
    int unsigned kind;
    int unsigned ntags;
    int unsigned cut;
    logic [7:0]  tq [$];
    pkt_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 19) begin
      repeat ($urandom_range(1, 12)) pkt_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ntags = (kind == 18) ? $urandom_range(9, 11) : $urandom_range(0, MaxArgsDefault);
    repeat (ntags)
      case ($urandom_range(0, 2))
        0:       tq.push_back(CharInt);
        1:       tq.push_back(CharStr);
        default: tq.push_back(CharFloat);
      endcase
    if (kind == 14 && ntags > 0) tq[$urandom_range(0, ntags - 1)] = 8'($urandom_range(32, 126));
    put_rand_str($urandom_range(0, 9));
    pkt_q.push_back(CharComma);
    foreach (tq[i]) pkt_q.push_back(tq[i]);
    end_str();
    foreach (tq[i]) begin
      if (tq[i] == CharStr) put_rand_str($urandom_range(0, 7));
      else put_word();
    end
    case (kind)
      15: begin
        cut   = $urandom_range(1, pkt_q.size() - 1);
        pkt_q = pkt_q[0:cut-1];
      end
      16: repeat ($urandom_range(1, 5)) pkt_q.push_back(8'($urandom_range(0, 255)));
      17: pkt_q[$urandom_range(0, pkt_q.size() - 1)] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endfunction

  task automatic drive_byte(logic [7:0] b, logic fin);
    if (burst_left == 0) begin
      if (gaps_on && !hold_req) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   = 1'b1;
    data_byte_i  = b;
    final_byte_i = fin;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) drive_byte(pkt_q[i], i == pkt_q.size() - 1);
    packets_sent++;
    pkt_q.delete();
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (tracker.pending_items.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.kind     = kind_e'(item_kind_o);
        got.idx      = arg_index_o;
        got.atype    = arg_type_o;
        got.offset   = arg_offset_o;
        got.status   = status_o;
        got.addr_len = address_length_o;
        got.count    = tag_count_o;
        got.eor      = end_of_run_o;
        tracker.match_item(got);
      end
      if (in_valid_i && !in_stall_o) tracker.take_byte(data_byte_i, final_byte_i);
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned cnt;
    out_stall_i = 1'b0;
    mode        = 0;
    cnt         = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req    = 1'b0;
        holds_done++;
      end else begin
        cnt++;
        if (cnt % 48 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_stall_i = 1'b0;
          1:       out_stall_i = ($urandom_range(0, 3) == 0);
          2:       out_stall_i = ($urandom_range(0, 3) != 0);
          default: out_stall_i = (cnt % 4 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("watchdog: no request moved for %0d cycles", IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned rnd_start;
    int unsigned k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    final_byte_i = 1'b0;
    bytes_sent   = 0;
    packets_sent = 0;
    burst_left   = 0;
    holds_done   = 0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: well-formed messages and at least one message per error class
    put_str("/ab"); put_str(",i"); put_word(); send_packet();
    put_str("/osc/x"); put_str(",sfi"); put_str("hey"); put_word(); put_word(); send_packet();
    put_str(""); put_str(","); send_packet();
    put_str("/all"); put_str(",ifsifsfi");
    put_word(); put_word(); put_str(""); put_word(); put_word(); put_rand_str(5);
    put_word(); put_word(); send_packet();
    put_str("/x"); send_packet();
    put_str("/x"); put_str("i"); send_packet();
    put_str("/x"); put_str(""); send_packet();
    put_str("/x"); put_str(",iiiiiiiii"); put_word(); send_packet();
    put_str("/x"); put_str(",iq"); put_word(); put_word(); send_packet();
    put_chars("/ab"); send_packet();
    put_str("/x"); put_chars(",i"); send_packet();
    put_str("/x"); put_str(",ii"); put_word(); put_word(); pkt_q = pkt_q[0:13]; send_packet();
    put_str("/x"); put_str(",f"); send_packet();
    put_str("/x"); put_str(",i"); put_word(); pkt_q.push_back(8'($urandom_range(0, 255)));
    send_packet();
    // argument starts on the final byte
    put_str("/x"); put_str(",i"); pkt_q.push_back(8'($urandom_range(0, 255))); send_packet();
    drain();

    rnd_start = bytes_sent;
    k = 0;
    while (bytes_sent - rnd_start < RandBytes) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (k == 1 || k == 5) hold_req = 1'b1;
      build_random_packet();
      send_packet();
      if (k % 7 == 6) drain();
      k++;
    end
    drain();

    $display("%0d packets, %0d bytes; %0d descriptors, %0d receiver hold-offs",
             packets_sent, bytes_sent, tracker.desc_count, holds_done);
    $display("status items by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             tracker.status_count[0], tracker.status_count[1], tracker.status_count[2],
             tracker.status_count[3], tracker.status_count[4], tracker.status_count[5],
             tracker.status_count[6], tracker.status_count[7]);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
